[hw/rtl/iso8583_pkg.sv]
// ----------------------------------------------------------------------------
// iso8583_pkg
// Shared types, codes and helpers of the ISO 8583 message unpacker.
// ----------------------------------------------------------------------------
package iso8583_pkg;

    localparam int FIELD_COUNT = 128;
    localparam int STORE_BYTES = 2048;
    localparam int MAX_LEN     = 999;
    localparam int RES_DEPTH   = 8;

    // input selector (tuser)
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_DEF  = 1'b1;

    // result kinds (tuser)
    localparam logic [2:0] K_HEADER = 3'd0;
    localparam logic [2:0] K_TYPE   = 3'd1;
    localparam logic [2:0] K_CHAR   = 3'd2;
    localparam logic [2:0] K_FEND   = 3'd3;
    localparam logic [2:0] K_MEND   = 3'd4;

    // end status
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_EARLY = 3'd2;
    localparam logic [2:0] ST_OVMAX = 3'd3;
    localparam logic [2:0] ST_OV999 = 3'd4;
    localparam logic [2:0] ST_STORE = 3'd5;

    // length kinds
    localparam logic [1:0] LK_FIXED = 2'd0;
    localparam logic [1:0] LK_LLL   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HEADER_LEN = 2'd0;
    localparam logic [1:0] CFG_TYPE_ASCII = 2'd1;
    localparam logic [1:0] CFG_PFX_ASCII  = 2'd2;
    localparam logic [1:0] CFG_BM_ASCII   = 2'd3;

    typedef enum logic [2:0] {
        P_IDLE, P_HEADER, P_TYPE, P_BITMAP, P_PREFIX, P_DATA, P_DONE, P_ERROR
    } phase_t;

    typedef enum logic [1:0] {S_RUN, S_SCAN, S_WAIT, S_END} seq_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] fnum;
        logic [7:0] ch;
        logic [9:0] flen;
        logic [2:0] st;
        logic       last;
    } res_t;

    function automatic logic [7:0] hexch(input logic [3:0] v);
        return (v > 4'd9) ? (8'h37 + {4'b0, v}) : (8'h30 + {4'b0, v});
    endfunction

    function automatic logic [3:0] asc_nib(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h61)      v = c - 8'h57;
        else if (c >= 8'h41) v = c - 8'h37;
        else if (c >= 8'h30) v = c - 8'h30;
        else                 v = 8'h00;
        return v[3:0];
    endfunction

    function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] fnum,
                                    input logic [7:0] ch, input logic [9:0] flen,
                                    input logic [2:0] st);
        res_t r;
        r.kind = kind;
        r.fnum = fnum;
        r.ch   = ch;
        r.flen = flen;
        r.st   = st;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

[hw/rtl/iso8583_message_unpacker.sv]
// ----------------------------------------------------------------------------
// iso8583_message_unpacker
// Splits an ISO 8583 byte stream into header, type and field characters.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                    | payload
//  s_axis    | in  | tvalid/tready                | tuser=op, tlast=last, tdata=byte+def
//  m_axis    | out | tvalid/tready                | tuser=kind, tlast=last, tdata=result
//  cfg       | in  | cfg_we                       | cfg_index, cfg_data
//
// One message byte per cycle; input stalls during field search and message
// end. After the bitmap or the end of a field the next field is searched in
// the field table memory; each set bitmap bit takes one table read. Results
// drain from an 8-entry queue; input stalls while fewer than four entries are
// free. Reset is asynchronous; the field table is not cleared.
module iso8583_message_unpacker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte[7:0], def_field[14:8], def_length_kind[16:15],
    // def_max_length[26:17], def_type[29:27], zero[31:30]
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // operation
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // field_number[7:0], char_value[15:8], field_length[25:16],
    // status[28:26], zero[31:29]
    output logic [31:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last_of_run
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    import iso8583_pkg::*;

    logic [5:0]  hl_reg;
    logic        ta_reg, pa_reg, ba_reg;

    seq_t        state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [11:0] bc_reg, bc_next;
    logic [127:0] bm_reg, bm_next;
    logic [6:0]  cur_reg, cur_next;
    logic [9:0]  rem_reg, rem_next;
    logic [14:0] acc_reg, acc_next;
    logic [11:0] stored_reg, stored_next;
    logic        skip_reg, skip_next;
    logic [2:0]  err_reg, err_next;
    logic [5:0]  unit_reg, unit_next, units_reg, units_next;
    logic        bma_reg, bma_next, pfx_reg, pfx_next, stop_reg, stop_next;
    logic [1:0]  left_reg, left_next;
    logic [14:0] entry_reg, entry_next;
    logic [7:0]  scan_reg, scan_next;
    logic        pend_reg, pend_next;

    logic [14:0] tbl_mem [FIELD_COUNT];
    logic [14:0] rd_q;

    res_t        fifo_reg [RES_DEPTH];
    logic [2:0]  wp_reg, rp_reg;
    logic [3:0]  cnt_reg;
    res_t        pr [4];
    logic [2:0]  pn;
    res_t        head;

    logic        in_fire, fin, defload, pop, wide, do_adv;
    logic [7:0]  b, adv_from, fnum, lim;
    logic [3:0]  v;
    logic [14:0] e, newent;
    logic [9:0]  len, emax;
    logic [14:0] acc;
    logic [2:0]  st;

    function automatic logic ovf(input logic [9:0] l, input logic [2:0] typ,
                                 input logic [11:0] s);
        logic [10:0] nb;
        nb = (typ != 3'd0) ? (({1'b0, l} + 11'd1) >> 1) : {1'b0, l};
        return ({2'b0, nb} + {1'b0, s}) >= 13'(STORE_BYTES);
    endfunction

    function automatic logic odd_skip(input logic [9:0] l, input logic [2:0] typ);
        return (typ != 3'd0) && l[0] && (typ[1:0] != 2'd0);
    endfunction

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign fin     = in_fire && (s_axis_tuser == OP_BYTE);
    assign defload = in_fire && (s_axis_tuser == OP_DEF);
    assign b       = s_axis_tdata[7:0];
    assign newent  = {s_axis_tdata[16:15], s_axis_tdata[26:17], s_axis_tdata[29:27]};
    assign s_axis_tready = (state_reg == S_RUN) && (cnt_reg <= 4'd4);
    assign wide    = bma_reg ? (units_reg == 6'd32) : (units_reg == 6'd16);
    assign lim     = wide ? 8'd128 : 8'd64;
    assign fnum    = {1'b0, cur_reg} + 8'd1;

    // field table
    always_ff @(posedge clk)
    begin
        if (defload)
            tbl_mem[s_axis_tdata[14:8]] <= newent;
        rd_q <= tbl_mem[scan_reg[6:0]];
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        bc_next     = bc_reg;
        bm_next     = bm_reg;
        cur_next    = cur_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        stored_next = stored_reg;
        skip_next   = skip_reg;
        err_next    = err_reg;
        unit_next   = unit_reg;
        units_next  = units_reg;
        bma_next    = bma_reg;
        pfx_next    = pfx_reg;
        stop_next   = stop_reg;
        left_next   = left_reg;
        entry_next  = entry_reg;
        scan_next   = scan_reg;
        pend_next   = pend_reg;
        pn          = 3'd0;
        for (int i = 0; i < 4; i++)
            pr[i] = mk_res(K_HEADER, 8'd0, 8'd0, 10'd0, ST_OK);
        do_adv   = 1'b0;
        adv_from = 8'd0;
        v        = 4'd0;
        e        = entry_reg;
        emax     = entry_reg[12:3];
        len      = 10'd0;
        acc      = acc_reg;
        st       = ST_OK;

        case (state_reg)
            S_RUN:
            begin
                if (defload && (s_axis_tdata[14:8] == cur_reg))
                    entry_next = newent;
                if (fin)
                begin
                    bc_next = (bc_reg < 12'hFFF) ? (bc_reg + 12'd1) : bc_reg;
                    if (phase_reg == P_IDLE)
                    begin
                        if (hl_reg != 6'd0)
                        begin
                            phase_next = P_HEADER;
                            rem_next   = {4'b0, hl_reg};
                        end
                        else
                        begin
                            phase_next = P_TYPE;
                            rem_next   = ta_reg ? 10'd4 : 10'd2;
                            pfx_next   = ta_reg;
                        end
                    end
                    case (phase_next)
                        P_HEADER:
                        begin
                            pr[0] = mk_res(K_HEADER, 8'd0, b, 10'd0, ST_OK);
                            pn = 3'd1;
                            rem_next = rem_next - 10'd1;
                            if (rem_next == 10'd0)
                            begin
                                phase_next = P_TYPE;
                                rem_next   = ta_reg ? 10'd4 : 10'd2;
                                pfx_next   = ta_reg;
                            end
                        end
                        P_TYPE:
                        begin
                            if (pfx_next)
                            begin
                                pr[0] = mk_res(K_TYPE, 8'd0, b, 10'd0, ST_OK);
                                pn = 3'd1;
                            end
                            else
                            begin
                                pr[0] = mk_res(K_TYPE, 8'd0, hexch(b[7:4]), 10'd0, ST_OK);
                                pr[1] = mk_res(K_TYPE, 8'd0, hexch(b[3:0]), 10'd0, ST_OK);
                                pn = 3'd2;
                            end
                            rem_next = rem_next - 10'd1;
                            if (rem_next == 10'd0)
                            begin
                                phase_next = P_BITMAP;
                                bma_next   = ba_reg;
                                unit_next  = 6'd0;
                                units_next = 6'd0;
                            end
                        end
                        P_BITMAP:
                        begin
                            if (bma_reg)
                            begin
                                v = asc_nib(b);
                                if (unit_reg == 6'd0)
                                    units_next = v[3] ? 6'd32 : 6'd16;
                                for (int k = 0; k < 4; k++)
                                    if (v[3-k])
                                        bm_next[{unit_reg[4:0], 2'b00} + 7'(k)] = 1'b1;
                            end
                            else
                            begin
                                if (unit_reg == 6'd0)
                                    units_next = b[7] ? 6'd16 : 6'd8;
                                for (int k = 0; k < 8; k++)
                                    if (b[7-k])
                                        bm_next[{unit_reg[3:0], 3'b000} + 7'(k)] = 1'b1;
                            end
                            unit_next = unit_reg + 6'd1;
                            if (unit_next >= units_next)
                            begin
                                do_adv   = 1'b1;
                                adv_from = 8'd1;
                            end
                        end
                        P_PREFIX:
                        begin
                            if (pfx_reg)
                            begin
                                if (!stop_reg && (b >= 8'h30) && (b <= 8'h39))
                                    acc = 15'(acc_reg * 15'd10 + 15'(b - 8'h30));
                                else
                                    stop_next = 1'b1;
                            end
                            else
                                acc = 15'(acc_reg * 15'd100 + 15'(b[7:4]) * 15'd10
                                      + 15'(b[3:0]));
                            acc_next  = acc;
                            left_next = left_reg - 2'd1;
                            if (left_next == 2'd0)
                            begin
                                len = acc[9:0];
                                if (acc > {5'b0, emax})
                                begin
                                    err_next = ST_OVMAX;
                                    phase_next = P_ERROR;
                                end
                                else if (acc > 15'(MAX_LEN))
                                begin
                                    err_next = ST_OV999;
                                    phase_next = P_ERROR;
                                end
                                else if (ovf(len, entry_reg[2:0], stored_reg))
                                begin
                                    err_next = ST_STORE;
                                    phase_next = P_ERROR;
                                end
                                else
                                begin
                                    stored_next = stored_reg + {2'b0, len};
                                    if (len == 10'd0)
                                    begin
                                        pr[0] = mk_res(K_FEND, fnum, 8'd0, 10'd0, ST_OK);
                                        pn = 3'd1;
                                        do_adv   = 1'b1;
                                        adv_from = fnum;
                                    end
                                    else
                                    begin
                                        phase_next = P_DATA;
                                        rem_next   = len;
                                        skip_next  = odd_skip(len, entry_reg[2:0]);
                                    end
                                end
                            end
                        end
                        P_DATA:
                        begin
                            if (entry_reg[2:0] == 3'd0)
                            begin
                                pr[0] = mk_res(K_CHAR, fnum, b, 10'd0, ST_OK);
                                pn = 3'd1;
                                rem_next = rem_reg - 10'd1;
                            end
                            else if (skip_reg)
                            begin
                                pr[0] = mk_res(K_CHAR, fnum, hexch(b[3:0]), 10'd0, ST_OK);
                                pn = 3'd1;
                                skip_next = 1'b0;
                                rem_next = rem_reg - 10'd1;
                            end
                            else
                            begin
                                pr[0] = mk_res(K_CHAR, fnum, hexch(b[7:4]), 10'd0, ST_OK);
                                pn = 3'd1;
                                rem_next = rem_reg - 10'd1;
                                if (rem_next != 10'd0)
                                begin
                                    pr[1] = mk_res(K_CHAR, fnum, hexch(b[3:0]), 10'd0,
                                                   ST_OK);
                                    pn = 3'd2;
                                    rem_next = rem_next - 10'd1;
                                end
                            end
                            if (rem_next == 10'd0)
                            begin
                                pr[pn[1:0]] = mk_res(K_FEND, fnum, 8'd0, acc_reg[9:0], ST_OK);
                                pn = pn + 3'd1;
                                do_adv   = 1'b1;
                                adv_from = fnum;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    // mark the final transfer of this byte unless message end follows
                    if (!s_axis_tlast && (pn != 3'd0))
                        pr[2'(pn - 3'd1)].last = 1'b1;
                    if (do_adv)
                    begin
                        scan_next  = adv_from;
                        pend_next  = s_axis_tlast;
                        state_next = S_SCAN;
                    end
                    else if (s_axis_tlast)
                        state_next = S_END;
                end
            end
            S_SCAN:
            begin
                if (scan_reg >= lim)
                begin
                    phase_next = P_DONE;
                    state_next = pend_reg ? S_END : S_RUN;
                end
                else if ((scan_reg == 8'd0) || !bm_reg[scan_reg[6:0]])
                    scan_next = scan_reg + 8'd1;
                else
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                e    = rd_q;
                emax = rd_q[12:3];
                if ((e[14:13] == LK_FIXED) && (emax == 10'd0))
                begin
                    scan_next  = scan_reg + 8'd1;
                    state_next = S_SCAN;
                end
                else
                begin
                    cur_next   = scan_reg[6:0];
                    entry_next = e;
                    state_next = pend_reg ? S_END : S_RUN;
                    if (e[14:13] == LK_FIXED)
                    begin
                        if (emax > 10'(MAX_LEN))
                        begin
                            err_next = ST_OV999;
                            phase_next = P_ERROR;
                        end
                        else if (ovf(emax, e[2:0], stored_reg))
                        begin
                            err_next = ST_STORE;
                            phase_next = P_ERROR;
                        end
                        else
                        begin
                            stored_next = stored_reg + {2'b0, emax};
                            acc_next    = {5'b0, emax};
                            phase_next  = P_DATA;
                            rem_next    = emax;
                            skip_next   = odd_skip(emax, e[2:0]);
                        end
                    end
                    else
                    begin
                        phase_next = P_PREFIX;
                        acc_next   = 15'd0;
                        stop_next  = 1'b0;
                        pfx_next   = pa_reg;
                        if (pa_reg)
                            left_next = (e[14:13] == LK_LLL) ? 2'd3 : 2'd2;
                        else
                            left_next = (e[14:13] == LK_LLL) ? 2'd2 : 2'd1;
                    end
                end
            end
            S_END:
            begin
                if (bc_reg < 12'd10)           st = ST_SHORT;
                else if (err_reg != ST_OK)     st = err_reg;
                else if (phase_reg != P_DONE)  st = ST_EARLY;
                else                           st = ST_OK;
                pr[0] = mk_res(K_MEND, 8'd0, 8'd0, 10'd0, st);
                pr[0].last = 1'b1;
                pn = 3'd1;
                // drop all message state, keep table and registers
                phase_next  = P_IDLE;
                bc_next     = 12'd0;
                bm_next     = '0;
                cur_next    = 7'd0;
                rem_next    = 10'd0;
                acc_next    = 15'd0;
                stored_next = 12'd0;
                skip_next   = 1'b0;
                err_next    = ST_OK;
                unit_next   = 6'd0;
                units_next  = 6'd0;
                bma_next    = 1'b0;
                pfx_next    = 1'b0;
                left_next   = 2'd0;
                stop_next   = 1'b0;
                pend_next   = 1'b0;
                state_next  = S_RUN;
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hl_reg     <= 6'd0;
            ta_reg     <= 1'b0;
            pa_reg     <= 1'b0;
            ba_reg     <= 1'b0;
            state_reg  <= S_RUN;
            phase_reg  <= P_IDLE;
            bc_reg     <= 12'd0;
            bm_reg     <= '0;
            cur_reg    <= 7'd0;
            rem_reg    <= 10'd0;
            acc_reg    <= 15'd0;
            stored_reg <= 12'd0;
            skip_reg   <= 1'b0;
            err_reg    <= ST_OK;
            unit_reg   <= 6'd0;
            units_reg  <= 6'd0;
            bma_reg    <= 1'b0;
            pfx_reg    <= 1'b0;
            stop_reg   <= 1'b0;
            left_reg   <= 2'd0;
            entry_reg  <= 15'd0;
            scan_reg   <= 8'd0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEADER_LEN: hl_reg <= cfg_data;
                    CFG_TYPE_ASCII: ta_reg <= cfg_data[0];
                    CFG_PFX_ASCII:  pa_reg <= cfg_data[0];
                    CFG_BM_ASCII:   ba_reg <= cfg_data[0];
                    default:        hl_reg <= hl_reg;
                endcase
            end
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            bc_reg     <= bc_next;
            bm_reg     <= bm_next;
            cur_reg    <= cur_next;
            rem_reg    <= rem_next;
            acc_reg    <= acc_next;
            stored_reg <= stored_next;
            skip_reg   <= skip_next;
            err_reg    <= err_next;
            unit_reg   <= unit_next;
            units_reg  <= units_next;
            bma_reg    <= bma_next;
            pfx_reg    <= pfx_next;
            stop_reg   <= stop_next;
            left_reg   <= left_next;
            entry_reg  <= entry_next;
            scan_reg   <= scan_next;
            pend_reg   <= pend_next;
        end
    end

    // result queue
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign head = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
            if (3'(k) < pn)
                fifo_reg[wp_reg + 3'(k)] <= pr[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 3'd0;
            rp_reg  <= 3'd0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            wp_reg  <= wp_reg + pn;
            rp_reg  <= rp_reg + {2'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, pn} - {3'b0, pop};
        end
    end

    assign m_axis_tvalid = (cnt_reg != 4'd0);
    assign m_axis_tdata  = {3'b000, head.st, head.flen, head.ch, head.fnum};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule

[hw/rtl/iso8583_checker.sv]
// ----------------------------------------------------------------------------
// iso8583_checker
// Port-level checks of the ISO 8583 message unpacker.
// ----------------------------------------------------------------------------
module iso8583_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [5:0]  cfg_data
);
    import iso8583_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == K_MEND) |-> m_axis_tlast)
        else $error("message end not last of run");

    a_fnum_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == K_CHAR) || (m_axis_tuser == K_FEND))
        |-> (m_axis_tdata[7:0] != 8'd0) && (m_axis_tdata[7:0] <= 8'd128))
        else $error("field result without field number");

    a_fnum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == K_HEADER) || (m_axis_tuser == K_TYPE)
        || (m_axis_tuser == K_MEND)) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("field number on non-field result");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != K_MEND) |-> (m_axis_tdata[28:26] == ST_OK))
        else $error("status on non-end result");

endmodule

bind iso8583_message_unpacker iso8583_checker u_chk (.*);
